// File: rtl/mtgc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mtgc_pkg
// Shared types, token codes and the type follow graph of the grammar checker.
// ----------------------------------------------------------------------------
package mtgc_pkg;

    // Default size of the pitch set.
    localparam int PITCHES_DEF = 128;

    // Depth of the queue between the front and back parts (power of two).
    localparam int QDEPTH = 2;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_REMOVE_DUP = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHORDS     = 1'd1;

    // Token type codes.
    localparam logic [2:0] TT_BAR   = 3'd0;
    localparam logic [2:0] TT_POS   = 3'd1;
    localparam logic [2:0] TT_PROG  = 3'd2;
    localparam logic [2:0] TT_PITCH = 3'd3;
    localparam logic [2:0] TT_DRUM  = 3'd4;
    localparam logic [2:0] TT_CHORD = 3'd5;

    // Saturation limits.
    localparam logic [7:0]  BAR_MAX   = 8'd255;
    localparam logic [15:0] TOTAL_MAX = 16'hFFFF;

    // One classified word as it travels from the front to the back part.
    typedef struct packed {
        logic [2:0] tok_type;
        logic [7:0] tok_value;
        logic [5:0] bar_enc;
        logic [6:0] pos_enc;
        logic [3:0] pad_mask_count;
        logic       first;
        logic       allowed;
    } tok_entry_t;

    // Whether a token of type cur may follow a token of type prev.
    function automatic logic follow_allowed(input logic [2:0] prev,
                                            input logic [2:0] cur,
                                            input logic       chords);
        logic [7:0] set;
        begin
            case (prev)
                TT_BAR:   set = (8'd1 << TT_BAR) | (8'd1 << TT_POS);
                TT_POS:   set = (8'd1 << TT_PROG);
                TT_PROG:  set = (8'd1 << TT_PITCH) | (8'd1 << TT_DRUM)
                                | (chords ? (8'd1 << TT_CHORD) : 8'd0);
                TT_PITCH: set = (8'd1 << TT_PITCH) | (8'd1 << TT_PROG)
                                | (8'd1 << TT_BAR) | (8'd1 << TT_POS);
                TT_DRUM:  set = (8'd1 << TT_DRUM) | (8'd1 << TT_PROG)
                                | (8'd1 << TT_BAR) | (8'd1 << TT_POS);
                TT_CHORD: set = chords ? (8'd1 << TT_PITCH) : 8'd0;
                default:  set = 8'd0;
            endcase
            follow_allowed = set[cur];
        end
    endfunction

endpackage
`default_nettype wire

// File: rtl/music_token_grammar_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// music_token_grammar_checker
// Checks a stream of music tokens against the grammar and counts errors.
// ----------------------------------------------------------------------------
// Usage:
//   Input words arrive on in_valid/in_stall with one field per port; a word
//   is taken at a clock edge with in_valid high and in_stall low. Each word
//   gives exactly one result word on out_valid/out_stall: the running,
//   saturating error_count and the step_errors added by that word.
//   Configuration (remove_duplicates at index 0, chords_enabled at index 1)
//   is written through cfg_we/cfg_index/cfg_data while the block is idle.
// Timing:
//   One word per cycle sustained while out_stall stays low; out_valid rises
//   once the word has passed the queue and the output register. The front
//   part checks type succession, a two-word queue decouples it from the back
//   part, which runs the state checks and holds the output register; its
//   per-word state update of bar, position and pitch set sets that rate.
// Stalls and reset:
//   When out_stall holds the result, the queue takes up to two further words
//   and in_stall then rises. Reset empties the queue, drops out_valid and
//   sets the tracked state to its start values; no clearing pass is needed.
// ----------------------------------------------------------------------------
module music_token_grammar_checker
#(
    parameter int PITCHES = mtgc_pkg::PITCHES_DEF
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [mtgc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic                           cfg_data,
    input  wire logic                           in_valid,
    output      logic                           in_stall,
    input  wire logic [2:0]                     tok_type,
    input  wire logic [7:0]                     tok_value,
    input  wire logic [5:0]                     bar_enc,
    input  wire logic signed [6:0]              pos_enc,
    input  wire logic [3:0]                     pad_mask_count,
    input  wire logic                           first,
    output      logic                           out_valid,
    input  wire logic                           out_stall,
    output      logic [15:0]                    error_count,
    output      logic [4:0]                     step_errors
);

    logic                 remove_dup_reg;
    logic                 remove_dup_next;
    logic                 chords_reg;
    logic                 chords_next;
    logic                 push;
    logic                 pop;
    logic                 q_full;
    logic                 q_valid;
    mtgc_pkg::tok_entry_t push_entry;
    mtgc_pkg::tok_entry_t q_entry;

    // Configuration registers.
    always_comb
    begin
        remove_dup_next = remove_dup_reg;
        chords_next     = chords_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                mtgc_pkg::REG_REMOVE_DUP: remove_dup_next = cfg_data;
                mtgc_pkg::REG_CHORDS:     chords_next     = cfg_data;
                default:                  ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remove_dup_reg <= 1'b0;
            chords_reg     <= 1'b0;
        end
        else
        begin
            remove_dup_reg <= remove_dup_next;
            chords_reg     <= chords_next;
        end
    end

    assign in_stall = q_full;

    // Front part: accept and classify.
    mtgc_front u_front
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .q_full         (q_full),
        .chords_enabled (chords_reg),
        .tok_type       (tok_type),
        .tok_value      (tok_value),
        .bar_enc        (bar_enc),
        .pos_enc        (pos_enc),
        .pad_mask_count (pad_mask_count),
        .first          (first),
        .push           (push),
        .entry          (push_entry)
    );

    // Decoupling queue.
    mtgc_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .q_full     (q_full),
        .q_valid    (q_valid),
        .q_entry    (q_entry)
    );

    // Back part: state checks and result register.
    mtgc_back #(
        .PITCHES (PITCHES)
    ) u_back
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .remove_duplicates (remove_dup_reg),
        .q_valid           (q_valid),
        .q_entry           (q_entry),
        .pop               (pop),
        .out_stall         (out_stall),
        .out_valid         (out_valid),
        .error_count       (error_count),
        .step_errors       (step_errors)
    );

endmodule
`default_nettype wire

// File: rtl/mtgc_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mtgc_front
// Accepts input words and classifies the type succession against the
// follow graph, tracking the previous token type.
// ----------------------------------------------------------------------------
module mtgc_front
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               q_full,
    input  wire logic               chords_enabled,
    input  wire logic [2:0]         tok_type,
    input  wire logic [7:0]         tok_value,
    input  wire logic [5:0]         bar_enc,
    input  wire logic [6:0]         pos_enc,
    input  wire logic [3:0]         pad_mask_count,
    input  wire logic               first,
    output      logic               push,
    output      mtgc_pkg::tok_entry_t entry
);

    logic [2:0] prev_type_reg;
    logic [2:0] prev_type_next;

    // A word is taken whenever the queue has room.
    assign push = in_valid && !q_full;

    // Build the queue word with the succession verdict attached.
    always_comb
    begin
        entry.tok_type       = tok_type;
        entry.tok_value      = tok_value;
        entry.bar_enc        = bar_enc;
        entry.pos_enc        = pos_enc;
        entry.pad_mask_count = pad_mask_count;
        entry.first          = first;
        entry.allowed        = mtgc_pkg::follow_allowed(prev_type_reg, tok_type,
                                                        chords_enabled);
    end

    // The previous type always follows the stream, first word or not.
    always_comb
    begin
        prev_type_next = push ? tok_type : prev_type_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_type_reg <= mtgc_pkg::TT_BAR;
        end
        else
        begin
            prev_type_reg <= prev_type_next;
        end
    end

endmodule
`default_nettype wire

// File: rtl/mtgc_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mtgc_queue
// Short first-in first-out queue of classified words between the front
// and back parts.
// ----------------------------------------------------------------------------
module mtgc_queue
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire mtgc_pkg::tok_entry_t push_entry,
    input  wire logic                 pop,
    output      logic                 q_full,
    output      logic                 q_valid,
    output      mtgc_pkg::tok_entry_t q_entry
);

    localparam int PtrW = (mtgc_pkg::QDEPTH > 1) ? $clog2(mtgc_pkg::QDEPTH) : 1;
    localparam int CntW = $clog2(mtgc_pkg::QDEPTH + 1);
    localparam logic [CntW-1:0] DepthCnt = CntW'(mtgc_pkg::QDEPTH);

    mtgc_pkg::tok_entry_t slot_reg [mtgc_pkg::QDEPTH];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [PtrW-1:0] rd_ptr_next;
    logic [CntW-1:0] count_reg;
    logic [CntW-1:0] count_next;
    logic            do_push;
    logic            do_pop;

    assign q_full  = (count_reg == DepthCnt);
    assign q_valid = (count_reg != '0);
    assign q_entry = slot_reg[rd_ptr_reg];

    assign do_push = push && !q_full;
    assign do_pop  = pop && q_valid;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage slots carry payload only.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DepthCnt)
        else $error("queue fill count beyond depth");
`endif

endmodule
`default_nettype wire

// File: rtl/mtgc_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mtgc_back
// Carries out the grammar checks on classified words, keeps the bar,
// position and pitch state and registers the running error count.
// ----------------------------------------------------------------------------
module mtgc_back
#(
    parameter int PITCHES = mtgc_pkg::PITCHES_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 remove_duplicates,
    input  wire logic                 q_valid,
    input  wire mtgc_pkg::tok_entry_t q_entry,
    output      logic                 pop,
    input  wire logic                 out_stall,
    output      logic                 out_valid,
    output      logic [15:0]          error_count,
    output      logic [4:0]           step_errors
);

    localparam int IdxW = (PITCHES > 1) ? $clog2(PITCHES) : 1;
    localparam logic [8:0] PitchLim = 9'(PITCHES);

    logic [7:0]         cur_bar_reg;
    logic [7:0]         cur_bar_next;
    logic signed [6:0]  cur_pos_reg;
    logic signed [6:0]  cur_pos_next;
    logic [PITCHES-1:0] seen_reg;
    logic [PITCHES-1:0] seen_next;
    logic [15:0]        total_reg;
    logic [15:0]        total_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [15:0]        count_out_reg;
    logic [15:0]        count_out_next;
    logic [4:0]         step_out_reg;
    logic [4:0]         step_out_next;

    logic signed [6:0]  pos_s;
    logic signed [8:0]  value_s;
    logic signed [8:0]  cur_pos_w;
    logic signed [8:0]  pos_w;
    logic [IdxW-1:0]    pitch_idx;
    logic               pitch_in_set;
    logic [4:0]         step;
    logic [16:0]        sum;

    // Take a word when the output register is free or being emptied.
    assign pop = q_valid && (!out_valid_reg || !out_stall);

    assign out_valid   = out_valid_reg;
    assign error_count = count_out_reg;
    assign step_errors = step_out_reg;

    assign pos_s        = $signed(q_entry.pos_enc);
    assign value_s      = $signed({1'b0, q_entry.tok_value});
    assign cur_pos_w    = 9'(cur_pos_reg);
    assign pos_w        = 9'(pos_s);
    assign pitch_idx    = q_entry.tok_value[IdxW-1:0];
    assign pitch_in_set = ({1'b0, q_entry.tok_value} < PitchLim);

    // Grammar checks and state update for the word at the queue head.
    always_comb
    begin
        cur_bar_next = cur_bar_reg;
        cur_pos_next = cur_pos_reg;
        seen_next    = seen_reg;
        total_next   = total_reg;
        step         = 5'(q_entry.pad_mask_count);
        sum          = '0;
        if (pop)
        begin
            if (q_entry.first)
            begin
                // A first word seeds the state and adds nothing.
                cur_bar_next = {2'b00, q_entry.bar_enc};
                cur_pos_next = pos_s;
                seen_next    = '0;
                total_next   = '0;
                step         = '0;
            end
            else
            begin
                if (q_entry.allowed)
                begin
                    if (q_entry.tok_type == mtgc_pkg::TT_BAR)
                    begin
                        if (cur_bar_reg != mtgc_pkg::BAR_MAX)
                        begin
                            cur_bar_next = cur_bar_reg + 8'd1;
                        end
                        cur_pos_next = -7'sd1;
                        seen_next    = '0;
                    end
                    else if (remove_duplicates
                             && q_entry.tok_type == mtgc_pkg::TT_PITCH)
                    begin
                        if (pitch_in_set)
                        begin
                            if (seen_reg[pitch_idx])
                            begin
                                step = step + 5'd1;
                            end
                            else
                            begin
                                seen_next[pitch_idx] = 1'b1;
                            end
                        end
                    end
                    else if (q_entry.tok_type == mtgc_pkg::TT_POS)
                    begin
                        if (value_s <= cur_pos_w || value_s != pos_w)
                        begin
                            step = step + 5'd1;
                        end
                        else
                        begin
                            // The value equals the encoding here, so it fits.
                            cur_pos_next = $signed(q_entry.tok_value[6:0]);
                            seen_next    = '0;
                        end
                    end
                    else if (q_entry.tok_type == mtgc_pkg::TT_PROG)
                    begin
                        seen_next = '0;
                    end
                    // Encodings must not fall behind the updated tracking.
                    if (pos_s < cur_pos_next
                        || {2'b00, q_entry.bar_enc} < cur_bar_next)
                    begin
                        step = step + 5'd1;
                    end
                end
                else
                begin
                    step = step + 5'd1;
                end
                sum = {1'b0, total_reg} + 17'(step);
                total_next = sum[16] ? mtgc_pkg::TOTAL_MAX : sum[15:0];
            end
        end
    end

    // Output register with hold while the receiver stalls.
    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        count_out_next = count_out_reg;
        step_out_next  = step_out_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
            count_out_next = total_next;
            step_out_next  = step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_bar_reg   <= '0;
            cur_pos_reg   <= -7'sd1;
            seen_reg      <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_bar_reg   <= cur_bar_next;
            cur_pos_reg   <= cur_pos_next;
            seen_reg      <= seen_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        count_out_reg <= count_out_next;
        step_out_reg  <= step_out_next;
    end

`ifndef SYNTHESIS
    a_first_clears: assert property (@(posedge clk) disable iff (!rst_n)
        pop && q_entry.first |=> error_count == 16'd0 && step_errors == 5'd0)
        else $error("first word did not give a zero result");
    a_bad_follow: assert property (@(posedge clk) disable iff (!rst_n)
        pop && !q_entry.first && !q_entry.allowed |=> step_errors != 5'd0)
        else $error("disallowed succession not counted");
    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> step_errors <= 5'd17)
        else $error("step error count out of range");
    a_total_mono: assert property (@(posedge clk) disable iff (!rst_n)
        pop && !q_entry.first |=> total_reg >= $past(total_reg))
        else $error("running total fell without a first word");
`endif

endmodule
`default_nettype wire

// File: tb/mtgc_error_tally_checker.sv
// ----------------------------------------------------------------------------
// mtgc_error_tally_checker
// Watches the input, output and register ports of the grammar checker. It
// keeps its own copy of the grammar state, works out the error tally that
// each accepted input word must produce, and compares it with the result
// words in order. The number of failures and of results still due are
// passed to the testbench top.
// ----------------------------------------------------------------------------
module mtgc_error_tally_checker
#(
    parameter int PITCHES = mtgc_pkg::PITCHES_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [mtgc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic                           cfg_data,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  logic [2:0]                     tok_type,
    input  logic [7:0]                     tok_value,
    input  logic [5:0]                     bar_enc,
    input  logic signed [6:0]              pos_enc,
    input  logic [3:0]                     pad_mask_count,
    input  logic                           first,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  logic [15:0]                    error_count,
    input  logic [4:0]                     step_errors,
    output int                             fail_count,
    output int                             outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import mtgc_pkg::*;

    // One expected result word.
    typedef struct packed {
        logic [15:0] total;
        logic [4:0]  step;
    } tally_t;

    // Shadow copy of the registers and the grammar state.
    logic               flag_dups;
    logic               chords_on;
    logic [2:0]         last_type;
    int                 bar_now;
    int                 pos_now;
    logic [PITCHES-1:0] pitches_here;
    int                 running_total;

    // Tallies still owed by the block, oldest first.
    tally_t expected_tallies[$];

    int mismatches = 0;
    int waiting = 0;

    assign fail_count  = mismatches;
    assign outstanding = waiting;

    // Whether a token of type cur may come straight after one of type prev.
    function automatic logic succession_ok(input logic [2:0] prev, input logic [2:0] cur,
                                           input logic chords);
        logic ok;
        case (cur)
            TT_BAR:   ok = prev inside {TT_BAR, TT_PITCH, TT_DRUM};
            TT_POS:   ok = prev inside {TT_BAR, TT_PITCH, TT_DRUM};
            TT_PROG:  ok = prev inside {TT_POS, TT_PITCH, TT_DRUM};
            TT_PITCH: ok = (prev inside {TT_PROG, TT_PITCH}) || (chords && prev == TT_CHORD);
            TT_DRUM:  ok = prev inside {TT_PROG, TT_DRUM};
            TT_CHORD: ok = chords && prev == TT_PROG;
            default:  ok = 1'b0;
        endcase
        return ok;
    endfunction

    // Advances the grammar state by one word and returns the tally it gives.
    function automatic tally_t tally_word(input logic [2:0] kind, input logic [7:0] value,
                                          input logic [5:0] bar, input logic signed [6:0] pos,
                                          input logic [3:0] pads, input logic lead);
        tally_t res;
        int     step;
        int     posv;
        int     valv;
        int     barv;
        posv = int'(pos);
        valv = int'(value);
        barv = int'(bar);

        // A leading word only seeds the state.
        if (lead) begin
            last_type     = kind;
            bar_now       = barv;
            pos_now       = posv;
            pitches_here  = '0;
            running_total = 0;
            res.total     = '0;
            res.step      = '0;
            return res;
        end

        step = int'(pads);
        if (succession_ok(last_type, kind, chords_on)) begin
            case (kind)
                TT_BAR:
                begin
                    if (bar_now < int'(BAR_MAX))
                        bar_now++;
                    pos_now      = -1;
                    pitches_here = '0;
                end
                TT_PITCH:
                begin
                    // Pitches beyond the set are neither checked nor recorded.
                    if (flag_dups && valv < PITCHES) begin
                        if (pitches_here[valv])
                            step++;
                        else
                            pitches_here[valv] = 1'b1;
                    end
                end
                TT_POS:
                begin
                    if (valv <= pos_now || valv != posv) begin
                        step++;
                    end
                    else begin
                        pos_now      = valv;
                        pitches_here = '0;
                    end
                end
                TT_PROG:
                begin
                    pitches_here = '0;
                end
                default:
                begin
                end
            endcase
            // Encodings must not fall behind the tracked bar and position.
            if (posv < pos_now || barv < bar_now)
                step++;
        end
        else begin
            step++;
        end
        last_type = kind;

        running_total = running_total + step;
        if (running_total > int'(TOTAL_MAX))
            running_total = int'(TOTAL_MAX);
        res.total = 16'(running_total);
        res.step  = 5'(step);
        return res;
    endfunction

    // Reports the first few failures in full and counts all of them.
    function automatic void log_mismatch(input tally_t want, input tally_t got,
                                         input bit orphan);
        if (mismatches < 10) begin
            if (orphan)
                $display("%0t: result word with none due: error_count %0d step_errors %0d",
                         $realtime, got.total, got.step);
            else
                $display("%0t: error_count exp %0d got %0d, step_errors exp %0d got %0d",
                         $realtime, want.total, got.total, want.step, got.step);
        end
        mismatches++;
    endfunction

    // Results are checked before new words are predicted, as a result can
    // never belong to the word taken at the same edge.
    always @(posedge clk or negedge rst_n) begin
        tally_t want;
        tally_t got;
        if (!rst_n) begin
            flag_dups     = 1'b0;
            chords_on     = 1'b0;
            last_type     = TT_BAR;
            bar_now       = 0;
            pos_now       = -1;
            pitches_here  = '0;
            running_total = 0;
            expected_tallies.delete();
            waiting <= 0;
        end
        else begin
            if (out_valid && !out_stall) begin
                got.total = error_count;
                got.step  = step_errors;
                if (expected_tallies.size() == 0) begin
                    log_mismatch(got, got, 1'b1);
                end
                else begin
                    want = expected_tallies.pop_front();
                    if (got.total !== want.total || got.step !== want.step)
                        log_mismatch(want, got, 1'b0);
                end
            end

            // New tallies join at the tail of the queue.
            if (in_valid && !in_stall)
                expected_tallies.insert(expected_tallies.size(),
                                        tally_word(tok_type, tok_value, bar_enc, pos_enc,
                                                   pad_mask_count, first));

            if (cfg_we) begin
                if (cfg_index == REG_REMOVE_DUP)
                    flag_dups = cfg_data;
                else if (cfg_index == REG_CHORDS)
                    chords_on = cfg_data;
            end

            waiting <= expected_tallies.size();
        end
    end

endmodule

// File: tb/music_token_grammar_checker_test.sv
// ----------------------------------------------------------------------------
// music_token_grammar_checker_test
// Drives the grammar checker with a short directed run over each rule and
// corner, then with random token streams shaped like real bars under several
// register settings and handshake loads, and finally with a stream of bars
// that drives the bar count into saturation. The checker module beside the
// block predicts and compares every result word.
// ----------------------------------------------------------------------------
module music_token_grammar_checker_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mtgc_pkg::*;

    // Type codes that the grammar never allows.
    localparam logic [2:0] TT_OTHER = 3'd6;
    localparam logic [2:0] TT_SPARE = 3'd7;

    localparam int CYCLE_LIMIT    = 300000;
    localparam int HOLD_CYCLES    = 60;
    localparam int RANDOM_WORDS   = 120;
    localparam int SATURATE_WORDS = 200;

    // Register plan of the random phases, one bit per phase.
    localparam bit [5:0] DUP_PLAN   = 6'b010101;
    localparam bit [5:0] CHORD_PLAN = 6'b010011;

    // One input word as the sender builds it.
    typedef struct packed {
        logic [2:0]        kind;
        logic [7:0]        value;
        logic [5:0]        bar;
        logic signed [6:0] pos;
        logic [3:0]        pads;
        logic              lead;
    } tok_word_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic                 cfg_data = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [2:0]           tok_type = '0;
    logic [7:0]           tok_value = '0;
    logic [5:0]           bar_enc = '0;
    logic signed [6:0]    pos_enc = '0;
    logic [3:0]           pad_mask_count = '0;
    logic                 first = 1'b0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [15:0]          error_count;
    logic [4:0]           step_errors;

    int fail_count;
    int outstanding;

    // Handshake load and the long receiver hold-off.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_requests = 0;
    int holds_served = 0;
    int hold_left = 0;

    // Where the random stream believes the grammar stands.
    logic       gen_chords = 1'b0;
    logic [2:0] gen_prev = TT_BAR;
    int         gen_bar = 0;
    int         gen_pos = -1;

    int cycles = 0;

    music_token_grammar_checker dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .tok_type       (tok_type),
        .tok_value      (tok_value),
        .bar_enc        (bar_enc),
        .pos_enc        (pos_enc),
        .pad_mask_count (pad_mask_count),
        .first          (first),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .error_count    (error_count),
        .step_errors    (step_errors)
    );

    mtgc_error_tally_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .tok_type       (tok_type),
        .tok_value      (tok_value),
        .bar_enc        (bar_enc),
        .pos_enc        (pos_enc),
        .pad_mask_count (pad_mask_count),
        .first          (first),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .error_count    (error_count),
        .step_errors    (step_errors),
        .fail_count     (fail_count),
        .outstanding    (outstanding)
    );

    // Clock.
    initial
    begin
        forever #5 clk = ~clk;
    end

    // Receiver: random stalls, or a long hold-off when the sender asks.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end
        else if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (holds_served != hold_requests) begin
            holds_served <= holds_served + 1;
            hold_left    <= HOLD_CYCLES - 1;
            out_stall    <= 1'b1;
        end
        else begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Run limit.
    initial
    begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("Verification failed");
        $finish;
    end

    function automatic tok_word_t word(input int kind, input int value, input int bar,
                                       input int pos, input int pads, input bit lead);
        tok_word_t w;
        w.kind  = 3'(kind);
        w.value = 8'(value);
        w.bar   = 6'(bar);
        w.pos   = 7'(pos);
        w.pads  = 4'(pads);
        w.lead  = lead;
        return w;
    endfunction

    // Offers one word, with random idle cycles ahead of it, until it is taken.
    task automatic offer(input tok_word_t w);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        tok_type       <= w.kind;
        tok_value      <= w.value;
        bar_enc        <= w.bar;
        pos_enc        <= w.pos;
        pad_mask_count <= w.pads;
        first          <= w.lead;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Drops in_valid and lets every result drain.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_regs(input bit dups, input bit chords);
        cfg_we    <= 1'b1;
        cfg_index <= REG_REMOVE_DUP;
        cfg_data  <= dups;
        @(posedge clk);
        cfg_index <= REG_CHORDS;
        cfg_data  <= chords;
        @(posedge clk);
        cfg_we     <= 1'b0;
        gen_chords = chords;
    endtask

    // Mostly well-formed bars with random content, some noise and restarts.
    task automatic roll_word(output tok_word_t w);
        int         pick;
        int         v;
        logic [2:0] nxt;
        pick    = $urandom_range(99);
        w.kind  = 3'($urandom_range(7));
        w.value = 8'($urandom_range(255));
        w.bar   = 6'($urandom_range(63));
        w.pos   = 7'($urandom_range(127));
        w.pads  = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'd0;
        w.lead  = 1'b0;

        if (pick < 3) begin
            // Start of a new sequence.
            w.lead = 1'b1;
            if ($urandom_range(1) == 0)
                w.pos = -7'sd1;
            gen_prev = w.kind;
            gen_bar  = int'(w.bar);
            gen_pos  = int'($signed(w.pos));
        end
        else if (pick < 15) begin
            gen_prev = w.kind;
        end
        else begin
            case (gen_prev)
                TT_BAR:   nxt = ($urandom_range(3) == 0) ? TT_BAR : TT_POS;
                TT_POS:   nxt = TT_PROG;
                TT_PROG:
                begin
                    v = $urandom_range(2);
                    if (v == 0)
                        nxt = TT_DRUM;
                    else if (v == 1 || !gen_chords)
                        nxt = TT_PITCH;
                    else
                        nxt = TT_CHORD;
                end
                TT_PITCH, TT_DRUM:
                begin
                    v = $urandom_range(9);
                    if (v < 6)
                        nxt = gen_prev;
                    else if (v == 6)
                        nxt = TT_PROG;
                    else if (v == 7)
                        nxt = TT_BAR;
                    else
                        nxt = TT_POS;
                end
                TT_CHORD: nxt = TT_PITCH;
                default:  nxt = TT_BAR;
            endcase
            // Close the bar before the positions run out.
            if (nxt == TT_POS && gen_pos > 58)
                nxt = TT_BAR;

            w.kind = nxt;
            w.pos  = (gen_pos < 0) ? -7'sd1 : 7'(gen_pos);
            case (nxt)
                TT_BAR:
                begin
                    if (gen_bar < 63)
                        gen_bar++;
                    gen_pos = -1;
                    w.pos   = -7'sd1;
                end
                TT_POS:
                begin
                    // Now and then the random value and encoding stay as a
                    // broken position.
                    v = gen_pos + 1 + int'($urandom_range(3));
                    if ($urandom_range(11) != 0) begin
                        w.value = 8'(v);
                        w.pos   = 7'(v);
                        gen_pos = v;
                    end
                end
                TT_PITCH:
                begin
                    // A narrow range so that pitches repeat within a position.
                    if ($urandom_range(19) != 0)
                        w.value = 8'(48 + int'($urandom_range(7)));
                end
                default:
                begin
                end
            endcase
            w.bar = 6'(gen_bar);
            if ($urandom_range(9) == 0)
                w.bar = 6'($urandom_range(63));
            gen_prev = nxt;
        end
    endtask

    // Stimulus and verdict.
    initial
    begin
        tok_word_t w;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words with duplicate flagging and chords on.
        write_regs(1'b1, 1'b1);
        offer(word(TT_BAR,   255,  0,  -1, 15, 1'b1));
        offer(word(TT_BAR,     0,  1,  -1,  0, 1'b0));
        offer(word(TT_POS,     0,  1,   0,  0, 1'b0));
        offer(word(TT_PROG,  255,  1,   0,  0, 1'b0));
        offer(word(TT_CHORD,   0,  1,   0,  0, 1'b0));
        offer(word(TT_PITCH,  60,  1,   0,  0, 1'b0));
        offer(word(TT_PITCH,  60,  1,   0,  0, 1'b0));
        offer(word(TT_PITCH, 200,  1,   0,  0, 1'b0));
        offer(word(TT_PITCH, 127,  1,   0,  0, 1'b0));
        offer(word(TT_POS,     0,  1,   0,  0, 1'b0));
        offer(word(TT_PROG,    7,  1,   0,  0, 1'b0));
        offer(word(TT_DRUM,   36,  1,   0,  0, 1'b0));
        offer(word(TT_POS,     5,  1,   6,  0, 1'b0));
        offer(word(TT_PROG,    0,  0, -64,  0, 1'b0));
        offer(word(TT_PITCH,  60, 63,  63,  0, 1'b0));
        offer(word(TT_OTHER,   0, 63,  63,  3, 1'b0));
        offer(word(TT_PITCH,  61, 63,  63,  0, 1'b0));
        offer(word(TT_SPARE, 255, 63,  63, 15, 1'b0));
        offer(word(TT_BAR,     0,  0,  -1,  0, 1'b0));
        offer(word(TT_CHORD,   0, 63, -64,  0, 1'b1));
        offer(word(TT_PITCH, 127, 63,  63,  0, 1'b0));

        // Chords off: a chord neither follows a program nor leads a pitch,
        // and repeated pitches pass.
        settle();
        write_regs(1'b0, 1'b0);
        offer(word(TT_CHORD,   0,  0,  -1,  0, 1'b1));
        offer(word(TT_PITCH,  60,  0,  -1,  0, 1'b0));
        offer(word(TT_PITCH,  60,  0,  -1,  0, 1'b0));
        offer(word(TT_PROG,    0,  0,  -1,  0, 1'b0));
        offer(word(TT_CHORD,   0,  0,  -1,  0, 1'b0));

        // Random phases over the register plan and three handshake loads.
        for (int ph = 0; ph < 6; ph++) begin
            settle();
            write_regs(DUP_PLAN[ph], CHORD_PLAN[ph]);
            case (ph / 2)
                0:
                begin
                    send_idle_pct = 32;
                    recv_idle_pct <= 69;
                end
                1:
                begin
                    send_idle_pct = 69;
                    recv_idle_pct <= 32;
                end
                default:
                begin
                    // No idling, and one long hold-off so the block fills up.
                    send_idle_pct = 0;
                    recv_idle_pct <= 0;
                    hold_requests <= hold_requests + 1;
                end
            endcase
            offer(word(TT_BAR, 0, 0, -1, 0, 1'b1));
            gen_prev = TT_BAR;
            gen_bar  = 0;
            gen_pos  = -1;
            for (int n = 0; n < RANDOM_WORDS; n++) begin
                roll_word(w);
                offer(w);
            end
        end

        // Bar after bar, each full of padding: the bar count saturates.
        settle();
        write_regs(1'b0, 1'b0);
        offer(word(TT_BAR, 0, 63, -1, 0, 1'b1));
        repeat (SATURATE_WORDS)
            offer(word(TT_BAR, $urandom_range(255), $urandom_range(63),
                       $urandom_range(127), 15, 1'b0));

        settle();
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// File: music_token_grammar_checker.f
rtl/mtgc_pkg.sv
rtl/mtgc_front.sv
rtl/mtgc_queue.sv
rtl/mtgc_back.sv
rtl/music_token_grammar_checker.sv
tb/mtgc_error_tally_checker.sv
tb/music_token_grammar_checker_test.sv
